/* rtl/weighted_graph_edge_collapse_assert.svh */
// Assertion macros used by the checker file of the edge collapse block.
`ifndef WEIGHTED_GRAPH_EDGE_COLLAPSE_ASSERT_SVH
`define WEIGHTED_GRAPH_EDGE_COLLAPSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGEC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WGEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wgec_pkg.sv */
// Types and constants shared by the edge collapse modules.
`default_nettype none
package wgec_pkg;

    localparam int VW = 16;
    localparam int WW = 24;

    localparam logic [1:0] ST_CONTRACT = 2'd0;
    localparam logic [1:0] ST_SELF     = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic [15:0] edge_weight;
        logic        final_edge;
    } in_t;

    typedef struct packed {
        logic [15:0] merged_low;
        logic [15:0] merged_high;
        logic [5:0]  step_number;
        logic [1:0]  status;
        logic        run_end;
    } out_t;

    typedef struct packed {
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
        logic [WW-1:0] w;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_RD_I,
        OP_RD_J,
        OP_RD_R1,
        OP_DUP_CHK,
        OP_SET_ERR,
        OP_STORE,
        OP_CLR_I,
        OP_SORT_HOLD,
        OP_SORT_CMP,
        OP_WR_BEST,
        OP_WR_I_INC,
        OP_PICK_SET,
        OP_PICK,
        OP_SHIFT,
        OP_DEC,
        OP_RENAME,
        OP_MRG_HOLD,
        OP_MRG_SUM,
        OP_J_INC,
        OP_I_INC,
        OP_EMIT,
        OP_EMIT_ERR,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] err_code;
    } cmd_t;

    typedef struct packed {
        logic self_loop;
        logic full;
        logic err_set;
        logic fin;
        logic i_lt_cnt;
        logic i1_lt_cnt;
        logic j_lt_cnt;
        logic r1_lt_cnt;
        logic pair_eq;
        logic cnt_zero;
    } status_t;

endpackage
`default_nettype wire

/* rtl/weighted_graph_edge_collapse.sv */
// Top level of the greedy edge contraction block (minimum- or maximum-weight edge first).
`default_nettype none
// Edges are loaded one request at a time with start while busy is low; each
// edge is kept with its lower vertex first in a single-port table memory of
// MAX_EDGES entries. A load walks the stored edges once for the duplicate
// check, one memory read and one compare per entry. The request flagged
// final_edge starts the collapse: every contraction pass selection-sorts
// the table, reads the chosen first or last edge, shifts the table down over
// it, renames the removed vertex in a second sweep and merges parallel edges
// in a pairwise sweep, with every step one access to the one table port.
// Each result appears on result for exactly one cycle with res_strobe high
// and cannot be held off by the receiver; the last result of a run has
// run_end set. A load error (self loop, duplicate pair or full table) is
// latched, later edges are ignored, and the final request then yields one
// result carrying the error code instead of contractions. The pick_last
// register must be written by the user only while busy is low; the block
// itself does not enforce this.
module weighted_graph_edge_collapse #(
    parameter int MAX_EDGES = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire wgec_pkg::in_t   req,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data,
    output wgec_pkg::out_t       result,
    output logic                 res_strobe
);
    import wgec_pkg::*;

    // Commands from the sequencer and status flags back from the datapath.
    cmd_t    cmd;
    status_t stat;

    wgec_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    wgec_datapath #(
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result),
        .res_strobe  (res_strobe)
    );

endmodule
`default_nettype wire

/* rtl/wgec_datapath.sv */
// Datapath of the edge collapse block: edge table memory, indices and result register.
`default_nettype none
module wgec_datapath #(
    parameter int MAX_EDGES = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data,
    input  wire wgec_pkg::in_t   req,
    input  wire wgec_pkg::cmd_t  cmd,
    output wgec_pkg::status_t    stat,
    output wgec_pkg::out_t       result,
    output logic                 res_strobe
);
    import wgec_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    entry_t mem [MAX_EDGES];
    entry_t rdata_reg;

    logic [CW-1:0] cnt_reg, i_reg, j_reg, r_reg, best_reg;
    logic [1:0]    err_reg;
    logic [5:0]    k_reg;
    logic          pick_last_reg;
    logic          res_strobe_reg;

    logic [VW-1:0] in_lo_reg, in_hi_reg, keep_reg, gone_reg;
    logic [15:0]   in_w_reg;
    logic          in_fin_reg;
    entry_t        ent_a_reg, ent_b_reg;
    out_t          result_reg;

    logic          rd_en, we;
    logic [AW-1:0] raddr, waddr;
    entry_t        wdata, renamed;
    logic [CW-1:0] i_plus1, j_plus1, r_plus1;
    logic [WW:0]   sum_wide;
    logic [WW-1:0] sum_sat;
    logic          dup_hit, w_less;

    assign i_plus1  = i_reg + 1'b1;
    assign j_plus1  = j_reg + 1'b1;
    assign r_plus1  = r_reg + 1'b1;
    assign sum_wide = {1'b0, ent_a_reg.w} + {1'b0, rdata_reg.w};
    assign sum_sat  = sum_wide[WW] ? {WW{1'b1}} : sum_wide[WW-1:0];
    assign dup_hit  = (rdata_reg.lo == in_lo_reg) && (rdata_reg.hi == in_hi_reg);
    assign w_less   = rdata_reg.w < ent_b_reg.w;

    // Rename the removed vertex to the kept one, keeping the lower vertex first.
    always_comb
    begin
        renamed = rdata_reg;
        if (rdata_reg.lo == gone_reg)
        begin
            renamed.lo = (keep_reg < rdata_reg.hi) ? keep_reg : rdata_reg.hi;
            renamed.hi = (keep_reg < rdata_reg.hi) ? rdata_reg.hi : keep_reg;
        end
        if (rdata_reg.hi == gone_reg)
        begin
            renamed.lo = (keep_reg < rdata_reg.lo) ? keep_reg : rdata_reg.lo;
            renamed.hi = (keep_reg < rdata_reg.lo) ? rdata_reg.lo : keep_reg;
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        we    = 1'b0;
        raddr = i_reg[AW-1:0];
        waddr = i_reg[AW-1:0];
        wdata = rdata_reg;
        unique case (cmd.op)
            OP_RD_I:     rd_en = 1'b1;
            OP_RD_J:
            begin
                rd_en = 1'b1;
                raddr = j_reg[AW-1:0];
            end
            OP_RD_R1:
            begin
                rd_en = 1'b1;
                raddr = r_plus1[AW-1:0];
            end
            OP_STORE:
            begin
                we    = 1'b1;
                waddr = cnt_reg[AW-1:0];
                wdata = '{lo: in_lo_reg, hi: in_hi_reg, w: WW'(in_w_reg)};
            end
            OP_WR_BEST:
            begin
                we    = 1'b1;
                waddr = best_reg[AW-1:0];
                wdata = ent_a_reg;
            end
            OP_WR_I_INC:
            begin
                we    = 1'b1;
                wdata = ent_b_reg;
            end
            OP_SHIFT:
            begin
                we    = 1'b1;
                waddr = r_reg[AW-1:0];
            end
            OP_RENAME:
            begin
                we    = 1'b1;
                wdata = renamed;
            end
            OP_MRG_SUM:
            begin
                we    = 1'b1;
                wdata = '{lo: ent_a_reg.lo, hi: ent_a_reg.hi, w: sum_sat};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            r_reg          <= '0;
            best_reg       <= '0;
            err_reg        <= ST_CONTRACT;
            k_reg          <= '0;
            pick_last_reg  <= 1'b0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            res_strobe_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                pick_last_reg <= cfg_wr_data;
            end
            unique case (cmd.op)
                OP_LATCH:    i_reg <= '0;
                OP_DUP_CHK:
                begin
                    if (dup_hit)
                    begin
                        err_reg <= ST_DUP;
                    end
                    i_reg <= i_plus1;
                end
                OP_SET_ERR:  err_reg <= cmd.err_code;
                OP_STORE:    cnt_reg <= cnt_reg + 1'b1;
                OP_CLR_I:    i_reg <= '0;
                OP_SORT_HOLD:
                begin
                    best_reg <= i_reg;
                    j_reg    <= i_plus1;
                end
                OP_SORT_CMP:
                begin
                    if (w_less)
                    begin
                        best_reg <= j_reg;
                    end
                    j_reg <= j_plus1;
                end
                OP_WR_I_INC: i_reg <= i_plus1;
                OP_PICK_SET: i_reg <= pick_last_reg ? cnt_reg - 1'b1 : '0;
                OP_PICK:     r_reg <= i_reg;
                OP_SHIFT:    r_reg <= r_plus1;
                OP_DEC:      cnt_reg <= cnt_reg - 1'b1;
                OP_RENAME:   i_reg <= i_plus1;
                OP_MRG_HOLD: j_reg <= i_plus1;
                OP_MRG_SUM:  r_reg <= j_reg;
                OP_J_INC:    j_reg <= j_plus1;
                OP_I_INC:    i_reg <= i_plus1;
                OP_EMIT:
                begin
                    res_strobe_reg <= 1'b1;
                    k_reg          <= k_reg + 1'b1;
                end
                OP_EMIT_ERR: res_strobe_reg <= 1'b1;
                OP_CLEAR:
                begin
                    cnt_reg <= '0;
                    err_reg <= ST_CONTRACT;
                    k_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                in_lo_reg  <= (req.vertex_a < req.vertex_b) ? req.vertex_a : req.vertex_b;
                in_hi_reg  <= (req.vertex_a < req.vertex_b) ? req.vertex_b : req.vertex_a;
                in_w_reg   <= req.edge_weight;
                in_fin_reg <= req.final_edge;
            end
            OP_SORT_HOLD:
            begin
                ent_a_reg <= rdata_reg;
                ent_b_reg <= rdata_reg;
            end
            OP_SORT_CMP:
            begin
                if (w_less)
                begin
                    ent_b_reg <= rdata_reg;
                end
            end
            OP_PICK:
            begin
                keep_reg <= rdata_reg.lo;
                gone_reg <= rdata_reg.hi;
            end
            OP_MRG_HOLD: ent_a_reg <= rdata_reg;
            OP_MRG_SUM:  ent_a_reg.w <= sum_sat;
            OP_EMIT:
            begin
                result_reg <= '{merged_low: keep_reg, merged_high: gone_reg,
                                step_number: k_reg, status: ST_CONTRACT,
                                run_end: (cnt_reg == '0)};
            end
            OP_EMIT_ERR:
            begin
                result_reg <= '{merged_low: '0, merged_high: '0, step_number: '0,
                                status: err_reg, run_end: 1'b1};
            end
            default: ;
        endcase
    end

    assign stat.self_loop = (in_lo_reg == in_hi_reg);
    assign stat.full      = (cnt_reg >= CW'(MAX_EDGES));
    assign stat.err_set   = (err_reg != ST_CONTRACT);
    assign stat.fin       = in_fin_reg;
    assign stat.i_lt_cnt  = (i_reg < cnt_reg);
    assign stat.i1_lt_cnt = (i_plus1 < cnt_reg);
    assign stat.j_lt_cnt  = (j_reg < cnt_reg);
    assign stat.r1_lt_cnt = (r_plus1 < cnt_reg);
    assign stat.pair_eq   = (rdata_reg.lo == ent_a_reg.lo) && (rdata_reg.hi == ent_a_reg.hi);
    assign stat.cnt_zero  = (cnt_reg == '0);

    assign result     = result_reg;
    assign res_strobe = res_strobe_reg;

endmodule
`default_nettype wire

/* rtl/wgec_ctrl.sv */
// Sequencer of the edge collapse block: loading checks, sort, contraction and merge passes.
`default_nettype none
module wgec_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire wgec_pkg::status_t stat,
    output wgec_pkg::cmd_t         cmd,
    output logic                   busy
);
    import wgec_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, L_CHK, L_ERR1, L_SCAN, L_DUP, L_ERR3, L_STORE, F_CHK,
        S_INIT, S_OUT, S_HOLD, S_SCAN, S_CMP, S_SWB, S_SWI,
        P_SET, P_RD, P_TAKE, R_LOOP, R_SHIFT, R_DEC,
        N_INIT, N_LOOP, N_WR,
        M_INIT, M_OUT, M_HOLD, M_INNER, M_CMP, M_SUM, M_JINC, M_NEXT,
        E_EMIT, E_ERR, E_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   ret_merge_reg, ret_merge_next;

    always_comb
    begin
        cmd.op         = OP_NOP;
        cmd.err_code   = ST_CONTRACT;
        state_next     = state_reg;
        ret_merge_next = ret_merge_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = L_CHK;
                end
            end
            L_CHK:
            begin
                priority if (stat.err_set) state_next = F_CHK;
                else if (stat.self_loop)   state_next = L_ERR1;
                else                       state_next = L_SCAN;
            end
            L_ERR1:
            begin
                cmd.op       = OP_SET_ERR;
                cmd.err_code = ST_SELF;
                state_next   = F_CHK;
            end
            L_SCAN:
            begin
                cmd.op = OP_RD_I;
                priority if (stat.i_lt_cnt) state_next = L_DUP;
                else if (stat.err_set)      state_next = F_CHK;
                else if (stat.full)         state_next = L_ERR3;
                else                        state_next = L_STORE;
            end
            L_DUP:
            begin
                cmd.op     = OP_DUP_CHK;
                state_next = L_SCAN;
            end
            L_ERR3:
            begin
                cmd.op       = OP_SET_ERR;
                cmd.err_code = ST_OVERFLOW;
                state_next   = F_CHK;
            end
            L_STORE:
            begin
                cmd.op     = OP_STORE;
                state_next = F_CHK;
            end
            F_CHK:
            begin
                priority if (!stat.fin)  state_next = S_IDLE;
                else if (stat.err_set)   state_next = E_ERR;
                else if (stat.cnt_zero)  state_next = E_CLEAR;
                else                     state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.op     = OP_CLR_I;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.op     = OP_RD_I;
                state_next = stat.i1_lt_cnt ? S_HOLD : P_SET;
            end
            S_HOLD:
            begin
                cmd.op     = OP_SORT_HOLD;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op     = OP_RD_J;
                state_next = stat.j_lt_cnt ? S_CMP : S_SWB;
            end
            S_CMP:
            begin
                cmd.op     = OP_SORT_CMP;
                state_next = S_SCAN;
            end
            S_SWB:
            begin
                cmd.op     = OP_WR_BEST;
                state_next = S_SWI;
            end
            S_SWI:
            begin
                cmd.op     = OP_WR_I_INC;
                state_next = S_OUT;
            end
            P_SET:
            begin
                cmd.op     = OP_PICK_SET;
                state_next = P_RD;
            end
            P_RD:
            begin
                cmd.op     = OP_RD_I;
                state_next = P_TAKE;
            end
            P_TAKE:
            begin
                cmd.op         = OP_PICK;
                ret_merge_next = 1'b0;
                state_next     = R_LOOP;
            end
            R_LOOP:
            begin
                cmd.op     = OP_RD_R1;
                state_next = stat.r1_lt_cnt ? R_SHIFT : R_DEC;
            end
            R_SHIFT:
            begin
                cmd.op     = OP_SHIFT;
                state_next = R_LOOP;
            end
            R_DEC:
            begin
                cmd.op     = OP_DEC;
                state_next = ret_merge_reg ? M_INNER : N_INIT;
            end
            N_INIT:
            begin
                cmd.op     = OP_CLR_I;
                state_next = N_LOOP;
            end
            N_LOOP:
            begin
                cmd.op     = OP_RD_I;
                state_next = stat.i_lt_cnt ? N_WR : M_INIT;
            end
            N_WR:
            begin
                cmd.op     = OP_RENAME;
                state_next = N_LOOP;
            end
            M_INIT:
            begin
                cmd.op     = OP_CLR_I;
                state_next = M_OUT;
            end
            M_OUT:
            begin
                cmd.op     = OP_RD_I;
                state_next = stat.i_lt_cnt ? M_HOLD : E_EMIT;
            end
            M_HOLD:
            begin
                cmd.op     = OP_MRG_HOLD;
                state_next = M_INNER;
            end
            M_INNER:
            begin
                cmd.op     = OP_RD_J;
                state_next = stat.j_lt_cnt ? M_CMP : M_NEXT;
            end
            M_CMP:
            begin
                state_next = stat.pair_eq ? M_SUM : M_JINC;
            end
            M_SUM:
            begin
                cmd.op         = OP_MRG_SUM;
                ret_merge_next = 1'b1;
                state_next     = R_LOOP;
            end
            M_JINC:
            begin
                cmd.op     = OP_J_INC;
                state_next = M_INNER;
            end
            M_NEXT:
            begin
                cmd.op     = OP_I_INC;
                state_next = M_OUT;
            end
            E_EMIT:
            begin
                cmd.op     = OP_EMIT;
                state_next = stat.cnt_zero ? E_CLEAR : S_INIT;
            end
            E_ERR:
            begin
                cmd.op     = OP_EMIT_ERR;
                state_next = E_CLEAR;
            end
            E_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_merge_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_merge_reg <= ret_merge_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

/* rtl/wgec_checker.sv */
// Port-level checker for the edge collapse block and its bind statement.
`default_nettype none
`include "weighted_graph_edge_collapse_assert.svh"
module wgec_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire wgec_pkg::out_t result,
    input wire logic           res_strobe
);
    import wgec_pkg::*;

    `WGEC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `WGEC_ASSERT_SAME(a_strobe_busy, res_strobe, busy, "result shown while idle")
    `WGEC_ASSERT_NEXT(a_strobe_gap, res_strobe, !res_strobe, "results on adjacent cycles")
    `WGEC_ASSERT_SAME(a_err_last, res_strobe && (result.status != ST_CONTRACT), result.run_end && (result.step_number == '0), "error result not a lone final result")

endmodule

bind weighted_graph_edge_collapse wgec_checker u_wgec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .result     (result),
    .res_strobe (res_strobe)
);
`default_nettype wire
